// ----- hdl/dsd_to_pcm_decimator_defines.svh -----
// Assertion helpers for the decimator. Clock and reset are taken by name.
`ifndef DSD_TO_PCM_DECIMATOR_DEFINES_SVH
`define DSD_TO_PCM_DECIMATOR_DEFINES_SVH

// same-cycle implication
`define DTP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DTP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/dtp_pkg.sv -----
package dtp_pkg;

    localparam int COEF_BITS          = 24;
    localparam int OUT_BITS           = 32;
    localparam int MAX_DECIMATION_DEF = 256;
    localparam int JOB_POS_W          = 10;
    localparam int ENTRY_W            = 12;
    localparam int TAPS_PER_GROUP     = 8;
    localparam int CFG_DATA_W         = 40;

    localparam logic [1:0] KIND_COEF  = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;
    localparam logic [1:0] KIND_REPOS = 2'd3;

    localparam logic [1:0] CFG_CHANNELS = 2'd0;
    localparam logic [1:0] CFG_DEC_LOG2 = 2'd1;
    localparam logic [1:0] CFG_TOTAL    = 2'd2;

    localparam logic [1:0] CHAN_STEREO = 2'd2;
    localparam logic [3:0] LOG2_MIN    = 4'd4;
    localparam logic [3:0] LOG2_MAX    = 4'd8;

    localparam logic STATUS_FRAME  = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef struct packed {
        logic [1:0]         kind;
        logic [12:0]        coef_index;
        logic signed [23:0] coef_value;
        logic [7:0]         byte_left;
        logic [7:0]         byte_right;
        logic [36:0]        start_byte;
        logic [36:0]        start_frame;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] sample_left;
        logic signed [31:0] sample_right;
        logic               status;
    } t_out_item;

    typedef struct packed {
        logic                 reject;
        logic                 stereo;
        logic [3:0]           l;
        logic [JOB_POS_W-1:0] pos;
    } t_job;

    typedef struct packed {
        logic                 we0;
        logic                 we1;
        logic [JOB_POS_W-1:0] addr;
        logic [ENTRY_W-1:0]   data0;
        logic [ENTRY_W-1:0]   data1;
    } t_ring_wr;

    typedef struct packed {
        logic                        we;
        logic [2:0]                  bank;
        logic [JOB_POS_W-1:0]        row;
        logic signed [COEF_BITS-1:0] value;
    } t_coef_wr;

endpackage

// ----- hdl/dtp_ram.sv -----
module dtp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/dtp_queue.sv -----
module dtp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dtp_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output dtp_pkg::t_job o_job
);

    dtp_pkg::t_job r_ent [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_job;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_job   = r_ent[r_rp];

endmodule

// ----- hdl/dtp_front.sv -----
module dtp_front #(
    parameter int MAX_DECIMATION = dtp_pkg::MAX_DECIMATION_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  dtp_pkg::t_in_item i_data,
    output logic              o_stall,
    input  logic              i_free,
    input  logic [1:0]        i_chan,
    input  logic [3:0]        i_dlog,
    input  logic [39:0]       i_total,
    output dtp_pkg::t_ring_wr o_ring_wr,
    output dtp_pkg::t_coef_wr o_coef_wr,
    output logic              o_push,
    output dtp_pkg::t_job     o_job
);

    localparam int RING     = 4 * MAX_DECIMATION;
    localparam int RP_W     = $clog2(RING);
    localparam int LOG_MAX  = $clog2(MAX_DECIMATION);
    localparam int NUM_TAPS = 32 * MAX_DECIMATION;

    localparam logic [2:0] F_CLEAR  = 3'd0;
    localparam logic [2:0] F_IDLE   = 3'd1;
    localparam logic [2:0] F_CALC1  = 3'd2;
    localparam logic [2:0] F_CALC2  = 3'd3;
    localparam logic [2:0] F_DECIDE = 3'd4;
    localparam logic [2:0] F_FCHK   = 3'd5;

    function automatic logic [3:0] eff_log2(input logic [3:0] dl);
        logic [3:0] v;
        v = dl;
        if (v < dtp_pkg::LOG2_MIN) v = dtp_pkg::LOG2_MIN;
        if (v > dtp_pkg::LOG2_MAX) v = dtp_pkg::LOG2_MAX;
        if (v > 4'(LOG_MAX)) v = 4'(LOG_MAX);
        return v;
    endfunction

    logic [2:0]        r_state, n_state;
    logic [RP_W-1:0]   r_clr, n_clr;
    dtp_pkg::t_in_item r_item, n_item;
    logic [39:0]       r_bytes, n_bytes;
    logic [39:0]       r_frames, n_frames;
    logic [RP_W-1:0]   r_rpos, n_rpos;
    logic [RP_W-1:0]   r_fpos, n_fpos;
    logic [3:0]        r_l, n_l;
    logic [40:0]       r_total, n_total;
    logic [40:0]       r_need, n_need;
    logic              r_early, n_early;
    logic [3:0]        r_valid, n_valid;
    logic              r_done, n_done;
    logic              r_ovf, n_ovf;
    logic [46:0]       r_endsrc, n_endsrc;

    logic [3:0]      l_now;
    logic [RP_W:0]   groups;
    logic [RP_W-1:0] gmask;
    logic [RP_W-1:0] pos;
    logic [40:0]     dec_m1;
    logic [42:0]     bt8;
    logic [42:0]     ts43;
    logic [42:0]     rem;
    logic [49:0]     e_sum;
    logic [49:0]     frame_lhs;
    logic [49:0]     frame_rhs;
    logic            stereo;
    logic [3:0]      push_valid;

    assign l_now     = eff_log2(i_dlog);
    assign groups    = (RP_W + 1)'(4) << r_l;
    assign gmask     = groups[RP_W-1:0] - RP_W'(1);
    assign pos       = r_rpos & gmask;
    assign dec_m1    = (41'd1 << l_now) - 41'd1;
    assign bt8       = {r_bytes, 3'b000};
    assign ts43      = {3'b000, i_total};
    assign rem       = ts43 - bt8;
    assign e_sum     = ({9'd0, r_total} << r_l) + (50'd16 << r_l) + 50'd7;
    assign frame_lhs = {7'd0, r_bytes, 3'b000};
    assign frame_rhs = ({10'd0, r_frames} << r_l) + (50'd16 << r_l);
    assign stereo    = (i_chan == dtp_pkg::CHAN_STEREO);
    assign push_valid = (r_item.kind == dtp_pkg::KIND_DATA) ? r_valid : 4'd0;

    assign o_stall = !((r_state == F_IDLE) && i_free);

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_item   = r_item;
        n_bytes  = r_bytes;
        n_frames = r_frames;
        n_rpos   = r_rpos;
        n_fpos   = r_fpos;
        n_l      = r_l;
        n_total  = r_total;
        n_need   = r_need;
        n_early  = r_early;
        n_valid  = r_valid;
        n_done   = r_done;
        n_ovf    = r_ovf;
        n_endsrc = r_endsrc;
        o_ring_wr = '0;
        o_coef_wr = '0;
        o_push    = 1'b0;
        o_job     = '0;
        case (r_state)
            F_CLEAR: begin
                o_ring_wr.we0  = 1'b1;
                o_ring_wr.we1  = 1'b1;
                o_ring_wr.addr = dtp_pkg::JOB_POS_W'(r_clr);
                n_clr = r_clr + RP_W'(1);
                if (r_clr == {RP_W{1'b1}}) begin
                    n_state = F_IDLE;
                end
            end
            F_IDLE: begin
                if (i_valid && i_free) begin
                    n_item  = i_data;
                    n_state = F_CALC1;
                end
            end
            F_CALC1: begin
                n_l     = l_now;
                n_total = ({1'b0, i_total} + dec_m1) >> l_now;
                n_need  = ({1'b0, i_total} + 41'd7) >> 3;
                n_early = (bt8 < ts43);
                n_valid = (rem < 43'd8) ? rem[3:0] : 4'd8;
                n_state = F_CALC2;
                case (r_item.kind)
                    dtp_pkg::KIND_COEF: begin
                        n_state = F_IDLE;
                        if ({1'b0, r_item.coef_index} >= 14'(NUM_TAPS)) begin
                            o_push       = 1'b1;
                            o_job.reject = 1'b1;
                        end else begin
                            o_coef_wr.we    = 1'b1;
                            o_coef_wr.bank  = r_item.coef_index[2:0];
                            o_coef_wr.row   = dtp_pkg::JOB_POS_W'(r_item.coef_index[RP_W+2:3]);
                            o_coef_wr.value = r_item.coef_value;
                        end
                    end
                    dtp_pkg::KIND_REPOS: begin
                        n_bytes  = {3'b000, r_item.start_byte};
                        n_frames = {3'b000, r_item.start_frame};
                        n_rpos   = '0;
                        n_clr    = '0;
                        n_state  = F_CLEAR;
                    end
                    default: begin
                        n_state = F_CALC2;
                    end
                endcase
            end
            F_CALC2: begin
                n_done   = ({1'b0, r_frames} >= r_total);
                n_ovf    = ({1'b0, r_bytes} >= r_need);
                n_endsrc = e_sum[49:3];
                n_state  = F_DECIDE;
            end
            F_DECIDE: begin
                n_state = F_IDLE;
                if (!r_done) begin
                    if ((r_item.kind == dtp_pkg::KIND_DATA) && r_ovf) begin
                        o_push       = 1'b1;
                        o_job.reject = 1'b1;
                    end else if ((r_item.kind == dtp_pkg::KIND_FLUSH) && r_early) begin
                        o_push       = 1'b1;
                        o_job.reject = 1'b1;
                    end else if ((r_item.kind == dtp_pkg::KIND_DATA)
                                 || ({7'd0, r_bytes} < r_endsrc)) begin
                        o_ring_wr.we0  = 1'b1;
                        o_ring_wr.we1  = stereo;
                        o_ring_wr.addr = dtp_pkg::JOB_POS_W'(pos);
                        o_ring_wr.data0 = {push_valid,
                            (push_valid == 4'd0) ? 8'd0 : r_item.byte_left};
                        o_ring_wr.data1 = {push_valid,
                            (push_valid == 4'd0) ? 8'd0 : r_item.byte_right};
                        n_bytes = r_bytes + 40'd1;
                        n_rpos  = (pos + RP_W'(1)) & gmask;
                        n_fpos  = pos;
                        n_state = F_FCHK;
                    end
                end
            end
            F_FCHK: begin
                n_state = F_IDLE;
                if (frame_lhs >= frame_rhs) begin
                    o_push       = 1'b1;
                    o_job.reject = 1'b0;
                    o_job.stereo = stereo;
                    o_job.l      = r_l;
                    o_job.pos    = dtp_pkg::JOB_POS_W'(r_fpos);
                    n_frames     = r_frames + 40'd1;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_CLEAR;
            r_clr    <= '0;
            r_bytes  <= '0;
            r_frames <= '0;
            r_rpos   <= '0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_bytes  <= n_bytes;
            r_frames <= n_frames;
            r_rpos   <= n_rpos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_fpos   <= n_fpos;
        r_l      <= n_l;
        r_total  <= n_total;
        r_need   <= n_need;
        r_early  <= n_early;
        r_valid  <= n_valid;
        r_done   <= n_done;
        r_ovf    <= n_ovf;
        r_endsrc <= n_endsrc;
    end

endmodule

// ----- hdl/dtp_back.sv -----
module dtp_back #(
    parameter int MAX_DECIMATION = dtp_pkg::MAX_DECIMATION_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_valid,
    input  dtp_pkg::t_job                        i_q_job,
    output logic                                 o_q_pop,
    output logic [$clog2(4*MAX_DECIMATION)-1:0]  o_ring_raddr,
    output logic [$clog2(4*MAX_DECIMATION)-1:0]  o_coef_raddr,
    input  logic [dtp_pkg::ENTRY_W-1:0]          i_ent0,
    input  logic [dtp_pkg::ENTRY_W-1:0]          i_ent1,
    input  logic [7:0][dtp_pkg::COEF_BITS-1:0]   i_coef,
    output logic                                 o_done,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output dtp_pkg::t_out_item                   o_data
);

    localparam int RING   = 4 * MAX_DECIMATION;
    localparam int RP_W   = $clog2(RING);
    localparam int CB     = dtp_pkg::COEF_BITS;
    localparam int OB     = dtp_pkg::OUT_BITS;
    localparam int ACC_W  = CB + $clog2(32 * MAX_DECIMATION) + 1;
    localparam int HALF_W = CB + 3;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (OB - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    function automatic logic signed [OB-1:0] sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] v;
        v = a;
        if (v > SAT_HI) v = SAT_HI;
        if (v < SAT_LO) v = SAT_LO;
        return v[OB-1:0];
    endfunction

    logic            r_busy;
    logic            r_run;
    logic [RP_W-1:0] r_g;
    logic [RP_W-1:0] r_pos;
    logic [3:0]      r_l;
    logic            r_stereo;
    logic            r_v1, r_last1;
    logic            r_v2, r_last2;
    logic            r_v3;
    logic            r_ovalid;
    dtp_pkg::t_out_item r_odata;
    logic signed [HALF_W-1:0] r_h0a, r_h0b, r_h1a, r_h1b;
    logic signed [ACC_W-1:0]  r_acc0, r_acc1;

    logic [RP_W:0]   groups;
    logic [RP_W-1:0] gmask;
    logic            last_g;
    logic [3:0]      cnt0, cnt1;
    logic signed [CB:0] t0 [8];
    logic signed [CB:0] t1 [8];

    assign groups       = (RP_W + 1)'(4) << r_l;
    assign gmask        = groups[RP_W-1:0] - RP_W'(1);
    assign last_g       = (r_g == gmask);
    assign o_ring_raddr = (r_pos - r_g) & gmask;
    assign o_coef_raddr = r_g;
    assign o_q_pop      = i_q_valid && !r_busy && !r_ovalid;
    assign o_done       = r_v3;
    assign o_valid      = r_ovalid;
    assign o_data       = r_odata;

    assign cnt0 = (i_ent0[11:8] > 4'd8) ? 4'd8 : i_ent0[11:8];
    assign cnt1 = (i_ent1[11:8] > 4'd8) ? 4'd8 : i_ent1[11:8];

    // only the top cnt bits of a short byte carry taps
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            logic signed [CB:0] cx;
            cx = {i_coef[b][CB-1], i_coef[b]};
            if ((5'(b) + {1'b0, cnt0}) >= 5'd8) begin
                t0[b] = i_ent0[b] ? cx : -cx;
            end else begin
                t0[b] = '0;
            end
            if ((5'(b) + {1'b0, cnt1}) >= 5'd8) begin
                t1[b] = i_ent1[b] ? cx : -cx;
            end else begin
                t1[b] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_run    <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (o_q_pop) begin
                if (i_q_job.reject) begin
                    r_ovalid <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_run  <= 1'b1;
                end
            end
            if (r_run && last_g) begin
                r_run <= 1'b0;
            end
            r_v1 <= r_run;
            r_v2 <= r_v1;
            r_v3 <= r_v2 && r_last2;
            if (r_v3) begin
                r_ovalid <= 1'b1;
                r_busy   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_g      <= '0;
            r_pos    <= i_q_job.pos[RP_W-1:0];
            r_l      <= i_q_job.l;
            r_stereo <= i_q_job.stereo;
            r_acc0   <= '0;
            r_acc1   <= '0;
            if (i_q_job.reject) begin
                r_odata.sample_left  <= '0;
                r_odata.sample_right <= '0;
                r_odata.status       <= dtp_pkg::STATUS_REJECT;
            end
        end else begin
            if (r_run) begin
                r_g <= r_g + RP_W'(1);
            end
            if (r_v2) begin
                r_acc0 <= r_acc0 + ACC_W'(r_h0a) + ACC_W'(r_h0b);
                r_acc1 <= r_acc1 + ACC_W'(r_h1a) + ACC_W'(r_h1b);
            end
        end
        r_last1 <= r_run && last_g;
        r_last2 <= r_last1;
        r_h0a <= HALF_W'(t0[0]) + HALF_W'(t0[1]) + HALF_W'(t0[2]) + HALF_W'(t0[3]);
        r_h0b <= HALF_W'(t0[4]) + HALF_W'(t0[5]) + HALF_W'(t0[6]) + HALF_W'(t0[7]);
        r_h1a <= HALF_W'(t1[0]) + HALF_W'(t1[1]) + HALF_W'(t1[2]) + HALF_W'(t1[3]);
        r_h1b <= HALF_W'(t1[4]) + HALF_W'(t1[5]) + HALF_W'(t1[6]) + HALF_W'(t1[7]);
        if (r_v3) begin
            r_odata.sample_left  <= sat(r_acc0);
            r_odata.sample_right <= r_stereo ? sat(r_acc1) : '0;
            r_odata.status       <= dtp_pkg::STATUS_FRAME;
        end
    end

endmodule

// ----- hdl/dsd_to_pcm_decimator.sv -----
// Channel  | Direction | Handshake          | Beat
// ---------+-----------+--------------------+---------------------
// input    | in        | i_valid / o_stall  | i_data  (t_in_item)
// output   | out       | o_valid / i_stall  | o_data  (t_out_item)
// config   | in        | i_cfg_we           | i_cfg_index, i_cfg_data
//
// In the front a coefficient write passes F_IDLE and F_CALC1; a data or flush beat
// also passes F_CALC2, F_DECIDE and, when it writes the ring, F_FCHK. In the back
// a frame reads 4*decimation rows: one 8-tap coefficient row and one ring entry
// per channel are read each cycle. Reset and reposition start a clearing pass over
// all 4*MAX_DECIMATION entries (1024 by default) of the byte ring; o_stall is high meanwhile.
// Input stalls while a frame is pending or being computed, or the queue is full.
`include "dsd_to_pcm_decimator_defines.svh"

module dsd_to_pcm_decimator #(
    parameter int MAX_DECIMATION = dtp_pkg::MAX_DECIMATION_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  dtp_pkg::t_in_item               i_data,
    output logic                            o_valid,
    input  logic                            i_stall,
    output dtp_pkg::t_out_item              o_data,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_index,
    input  logic [dtp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int RING = 4 * MAX_DECIMATION;
    localparam int RP_W = $clog2(RING);

    logic [1:0]  r_chan;
    logic [3:0]  r_dlog;
    logic [39:0] r_total;
    logic [1:0]  r_pend;

    dtp_pkg::t_ring_wr ring_wr;
    dtp_pkg::t_coef_wr coef_wr;
    dtp_pkg::t_job     f_job;
    dtp_pkg::t_job     q_job;
    logic              f_push;
    logic              q_valid;
    logic              q_full;
    logic              q_pop;
    logic              b_done;
    logic              push_frame;
    logic              in_acc;
    logic [RP_W-1:0]   ring_raddr;
    logic [RP_W-1:0]   coef_raddr;
    logic [dtp_pkg::ENTRY_W-1:0] ent0, ent1;
    logic [7:0][dtp_pkg::COEF_BITS-1:0] coef_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan  <= 2'd2;
            r_dlog  <= 4'd6;
            r_total <= 40'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dtp_pkg::CFG_CHANNELS: r_chan  <= i_cfg_data[1:0];
                dtp_pkg::CFG_DEC_LOG2: r_dlog  <= i_cfg_data[3:0];
                dtp_pkg::CFG_TOTAL:    r_total <= i_cfg_data[39:0];
                default: ;
            endcase
        end
    end

    assign push_frame = f_push && !f_job.reject;
    assign in_acc     = i_valid && !o_stall;

    // frames queued or in flight; ring and coefficients must not change under them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else begin
            r_pend <= r_pend + 2'(push_frame) - 2'(b_done);
        end
    end

    dtp_front #(.MAX_DECIMATION(MAX_DECIMATION)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_data    (i_data),
        .o_stall   (o_stall),
        .i_free    (!q_full && (r_pend == 2'd0)),
        .i_chan    (r_chan),
        .i_dlog    (r_dlog),
        .i_total   (r_total),
        .o_ring_wr (ring_wr),
        .o_coef_wr (coef_wr),
        .o_push    (f_push),
        .o_job     (f_job)
    );

    dtp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_job   (f_job),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_job   (q_job)
    );

    dtp_ram #(.WIDTH(dtp_pkg::ENTRY_W), .DEPTH(RING)) u_ring0 (
        .i_clk   (i_clk),
        .i_we    (ring_wr.we0),
        .i_waddr (ring_wr.addr[RP_W-1:0]),
        .i_wdata (ring_wr.data0),
        .i_raddr (ring_raddr),
        .o_rdata (ent0)
    );

    dtp_ram #(.WIDTH(dtp_pkg::ENTRY_W), .DEPTH(RING)) u_ring1 (
        .i_clk   (i_clk),
        .i_we    (ring_wr.we1),
        .i_waddr (ring_wr.addr[RP_W-1:0]),
        .i_wdata (ring_wr.data1),
        .i_raddr (ring_raddr),
        .o_rdata (ent1)
    );

    for (genvar k = 0; k < 8; k++) begin : g_coef
        dtp_ram #(.WIDTH(dtp_pkg::COEF_BITS), .DEPTH(RING)) u_coef (
            .i_clk   (i_clk),
            .i_we    (coef_wr.we && (coef_wr.bank == 3'(k))),
            .i_waddr (coef_wr.row[RP_W-1:0]),
            .i_wdata (coef_wr.value),
            .i_raddr (coef_raddr),
            .o_rdata (coef_rd[k])
        );
    end

    dtp_back #(.MAX_DECIMATION(MAX_DECIMATION)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_job      (q_job),
        .o_q_pop      (q_pop),
        .o_ring_raddr (ring_raddr),
        .o_coef_raddr (coef_raddr),
        .i_ent0       (ent0),
        .i_ent1       (ent1),
        .i_coef       (coef_rd),
        .o_done       (b_done),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data       (o_data)
    );

    `DTP_ASSERT_IMP(a_accept_idle, in_acc, r_pend == 2'd0, "beat accepted with frame pending")
    `DTP_ASSERT_IMP(a_queue_room, f_push, !q_full, "job queue overflow")
    `DTP_ASSERT_IMP(a_reject_zero, o_valid && (o_data.status == dtp_pkg::STATUS_REJECT), (o_data.sample_left == 32'sd0) && (o_data.sample_right == 32'sd0), "reject beat carries samples")
    `DTP_ASSERT_NXT(a_done_out, b_done, o_valid, "finished frame not presented")

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import dtp_pkg::*;

    localparam longint unsigned MASK40 = 64'hFF_FFFF_FFFF;
    localparam int IDLE_WAIT = 2200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_in_item in_data = '0;
    logic out_valid;
    logic out_stall = 1'b1;
    t_out_item out_data;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_val = '0;

    dsd_to_pcm_decimator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_data      (in_data),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_data      (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_idx),
        .i_cfg_data  (cfg_val)
    );

    always #5 i_clk = ~i_clk;

    // filter model state
    logic signed [COEF_BITS-1:0] taps [8192];
    logic [ENTRY_W-1:0] ring_hist [2][1024];
    int unsigned ring_wr;
    longint unsigned bytes_in, frames_out;
    logic [1:0] m_chans = CHAN_STEREO;
    logic [3:0] m_log2 = 4'd6;
    longint unsigned m_total = 1;

    t_in_item beats_q[$];
    t_out_item frames_q[$];
    int errors = 0;
    int gap_left = 0;
    int stall_left = 0;
    bit calm = 1'b0;
    logic in_taken = 1'b0;
    logic out_taken = 1'b0;

    function automatic int eff_log2(logic [3:0] lg);
        if (lg < LOG2_MIN) return LOG2_MIN;
        if (lg > LOG2_MAX) return LOG2_MAX;
        return lg;
    endfunction

    function automatic logic signed [31:0] clip32(longint s);
        if (s > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (s < -64'sd2147483648) return 32'sh8000_0000;
        return s[31:0];
    endfunction

    function automatic longint fir_sum(int ch, int unsigned groups, int unsigned pos);
        longint acc;
        int unsigned idx;
        int cnt;
        logic [ENTRY_W-1:0] e;
        acc = 0;
        idx = pos;
        for (int g = 0; g < groups; g++) begin
            e = ring_hist[ch][idx];
            cnt = (e[11:8] > 8) ? 8 : e[11:8];
            for (int b = 8 - cnt; b < 8; b++) begin
                if (e[b]) acc += longint'(taps[g*8+b]);
                else acc -= longint'(taps[g*8+b]);
            end
            idx = (idx + groups - 1) & (groups - 1);
        end
        return acc;
    endfunction

    task automatic predict_frame(t_in_item it);
        int l, chans;
        int unsigned groups, pos, nvalid;
        longint unsigned dec, nframes, endsrc, rem;
        t_out_item r;
        logic [7:0] bv;
        r = '0;
        case (it.kind)
            KIND_COEF: begin
                taps[it.coef_index] = it.coef_value;
                return;
            end
            KIND_REPOS: begin
                bytes_in = it.start_byte;
                frames_out = it.start_frame;
                ring_wr = 0;
                for (int c = 0; c < 2; c++)
                    for (int i = 0; i < 1024; i++) ring_hist[c][i] = '0;
                return;
            end
            default: ;
        endcase
        l = eff_log2(m_log2);
        dec = 64'd1 << l;
        groups = 4 << l;
        chans = (m_chans == CHAN_STEREO) ? 2 : 1;
        nframes = (m_total + dec - 1) >> l;
        if (frames_out >= nframes) return;
        r.status = STATUS_REJECT;
        if (it.kind == KIND_DATA) begin
            if (bytes_in + 1 > (m_total + 7) / 8) begin
                frames_q.push_back(r);
                return;
            end
            rem = m_total - bytes_in * 8;
            nvalid = (rem < 8) ? rem : 8;
        end else begin
            if (bytes_in * 8 < m_total) begin
                frames_q.push_back(r);
                return;
            end
            endsrc = (nframes * dec + groups * 4 + 7) / 8;
            if (bytes_in >= endsrc) return;
            nvalid = 0;
        end
        pos = ring_wr & (groups - 1);
        for (int c = 0; c < chans; c++) begin
            bv = (c == 0) ? it.byte_left : it.byte_right;
            if (nvalid == 0) bv = '0;
            ring_hist[c][pos] = {nvalid[3:0], bv};
        end
        bytes_in = (bytes_in + 1) & MASK40;
        ring_wr = (pos + 1) & (groups - 1);
        if (bytes_in * 8 >= frames_out * dec + groups * 4) begin
            r.status = STATUS_FRAME;
            r.sample_left = clip32(fir_sum(0, groups, pos));
            r.sample_right = (chans == 2) ? clip32(fir_sum(1, groups, pos)) : '0;
            frames_q.push_back(r);
            frames_out = (frames_out + 1) & MASK40;
        end
    endtask

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function int draw_wait();
        if ($urandom_range(0, 49) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    // input side
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_taken) begin
            // hold stalled beat
        end else if (gap_left > 0) begin
            in_valid <= 1'b0;
            gap_left--;
        end else if (beats_q.size() > 0) begin
            in_data <= beats_q.pop_front();
            in_valid <= 1'b1;
            gap_left = draw_wait();
        end else begin
            in_valid <= 1'b0;
        end
    end

    // output side stall
    always @(negedge i_clk) begin
        if (out_taken) stall_left = draw_wait();
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        in_taken <= in_valid & ~in_stall;
        out_taken <= out_valid & ~out_stall;
        if (i_rst_n && out_valid && !out_stall) begin
            if (frames_q.size() == 0) begin
                report("unexpected beat", out_data.sample_left, 0);
            end else begin
                want = frames_q.pop_front();
                if (out_data.sample_left !== want.sample_left)
                    report("sample_left", out_data.sample_left, want.sample_left);
                if (out_data.sample_right !== want.sample_right)
                    report("sample_right", out_data.sample_right, want.sample_right);
                if (out_data.status !== want.status)
                    report("status", out_data.status, want.status);
            end
        end
        if (i_rst_n && in_valid && !in_stall) predict_frame(in_data);
        if (i_rst_n && cfg_we) begin
            case (cfg_idx)
                CFG_CHANNELS: m_chans = cfg_val[1:0];
                CFG_DEC_LOG2: m_log2 = cfg_val[3:0];
                CFG_TOTAL:    m_total = cfg_val[39:0];
                default: ;
            endcase
        end
    end

    function automatic t_in_item make_beat(logic [1:0] k);
        t_in_item it;
        it = {$urandom, $urandom, $urandom, $urandom, $urandom};
        it.kind = k;
        return it;
    endfunction

    function automatic longint unsigned rand40();
        return {$urandom, $urandom} & MASK40;
    endfunction

    task automatic settle();
        while (beats_q.size() != 0 || in_valid) @(posedge i_clk);
        while (frames_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, longint unsigned val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_val <= val[CFG_DATA_W-1:0];
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_taps(int lo, int hi, int mode);
        t_in_item it;
        for (int i = lo; i < hi; i++) begin
            it = make_beat(KIND_COEF);
            it.coef_index = i;
            if (mode > 0) it.coef_value = 24'sh7F_FFFF;
            else if (mode < 0) it.coef_value = 24'sh80_0000;
            beats_q.push_back(it);
        end
        settle();
    endtask

    // one stream: configure if asked, reposition, bytes with an early flush, a byte past the end, flush to drain
    task automatic run_stream(logic [1:0] ch, logic [3:0] lg, longint unsigned tot,
                              bit do_cfg, longint unsigned sb, longint unsigned sf,
                              int fill, int switch_at, logic [3:0] lg_new,
                              inout int count);
        longint unsigned nb, dec, nfr, endsrc, nflush;
        t_in_item it;
        if (do_cfg) begin
            cfg_write(CFG_CHANNELS, ch);
            cfg_write(CFG_DEC_LOG2, lg);
            cfg_write(CFG_TOTAL, tot);
        end
        it = make_beat(KIND_REPOS);
        it.start_byte = sb;
        it.start_frame = sf;
        beats_q.push_back(it);
        nb = (tot + 7) / 8;
        for (longint unsigned i = sb; i < nb; i++) begin
            if (i == switch_at) begin
                settle();
                cfg_write(CFG_DEC_LOG2, lg_new);
                lg = lg_new;
            end
            it = make_beat(KIND_DATA);
            if (fill >= 0) begin
                it.byte_left = fill;
                it.byte_right = fill;
            end
            beats_q.push_back(it);
            if (i == sb && nb - sb > 1) beats_q.push_back(make_beat(KIND_FLUSH));
            count++;
        end
        beats_q.push_back(make_beat(KIND_DATA));
        dec = 64'd1 << eff_log2(lg);
        nfr = (tot + dec - 1) / dec;
        endsrc = (nfr * dec + 16 * dec + 7) / 8;
        nflush = (endsrc > nb) ? endsrc - nb + 2 : 2;
        for (longint unsigned i = 0; i < nflush; i++) beats_q.push_back(make_beat(KIND_FLUSH));
        count += nflush + 2;
        settle();
    endtask

    task automatic run_tail(logic [1:0] ch, logic [3:0] lg, inout int count);
        longint unsigned tot, nb, sb, sf;
        tot = rand40();
        if (tot < 1024) tot += 1024;
        nb = (tot + 7) / 8;
        sb = nb - $urandom_range(1, 40);
        sf = (sb * 8) >> eff_log2(lg);
        if ($urandom_range(0, 2) == 0) sf = {$urandom, $urandom} & 64'h1F_FFFF_FFFF;
        else sf = (sf > 16) ? sf - 16 - $urandom_range(0, 3) : 0;
        run_stream(ch, lg, tot, 1, sb, sf, -1, -1, lg, count);
    endtask

    function automatic logic [3:0] pick_log2();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 4'd4;
        if (r < 80) return 4'd5;
        if (r < 90) return 4'd6;
        if (r < 95) return 4'd7;
        if (r < 98) return $urandom_range(0, 3);
        return $urandom_range(8, 15);
    endfunction

    initial begin
        int n;
        t_in_item it;
        n = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        // load every tap, extremes at both ends
        for (int i = 0; i < 8192; i++) begin
            it = make_beat(KIND_COEF);
            it.coef_index = i;
            if (i == 0) it.coef_value = 24'sh7F_FFFF;
            if (i == 8191) it.coef_value = 24'sh80_0000;
            beats_q.push_back(it);
        end
        settle();

        // reset config: stereo, 64x, one sample bit
        run_stream(CHAN_STEREO, 4'd6, 1, 0, 0, 0, -1, -1, 4'd6, n);

        // saturation both ways
        set_taps(0, 512, 1);
        run_stream(CHAN_STEREO, 4'd4, 200, 1, 0, 0, 8'hFF, -1, 4'd4, n);
        set_taps(0, 512, -1);
        run_stream(CHAN_STEREO, 4'd4, 200, 1, 0, 0, 8'hFF, -1, 4'd4, n);
        run_stream(CHAN_STEREO, 4'd4, 100, 1, 0, 0, 8'h00, -1, 4'd4, n);
        set_taps(0, 512, 0);

        // odd channel counts, odd and extreme decimation
        run_stream(2'd1, 4'd4, 100, 1, 0, 0, -1, -1, 4'd4, n);
        run_stream(2'd0, 4'd0, 37, 1, 0, 0, -1, -1, 4'd0, n);
        run_stream(2'd3, 4'd7, 9, 1, 0, 0, -1, -1, 4'd7, n);
        run_stream(CHAN_STEREO, 4'd8, 300, 1, 0, 0, -1, -1, 4'd8, n);
        run_stream(2'd1, 4'd15, 1, 1, 0, 0, -1, -1, 4'd15, n);
        // decimation changed mid-stream
        run_stream(CHAN_STEREO, 4'd5, 400, 1, 0, 0, -1, 20, 4'd4, n);
        // largest stream, near its end
        run_stream(CHAN_STEREO, 4'd4, MASK40, 1, (MASK40 + 7) / 8 - 3,
                   ((MASK40 + 7) / 8 - 3) / 2 - 18, -1, -1, 4'd4, n);

        n = 0;
        while (n < 950) begin
            case ($urandom_range(0, 9))
                0, 1: run_tail($urandom_range(0, 3), pick_log2(), n);
                2: begin
                    repeat (6) begin
                        beats_q.push_back(make_beat($urandom_range(0, 3)));
                        n++;
                    end
                    settle();
                end
                default: run_stream($urandom_range(0, 3), pick_log2(), $urandom_range(1, 400),
                                    1, 0, 0, -1, -1, 4'd4, n);
            endcase
        end
        settle();
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
